[hw/rtl/htw_pkg.sv]
// ----------------------------------------------------------------------------
// htw_pkg
// Shared types and codes of the hashed timing wheel scheduler.
// ----------------------------------------------------------------------------
package htw_pkg;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_DEL     = 2'd1,
    OP_DEL_ALL = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_DEL    = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DISABLED  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  localparam logic [1:0] REG_TICK_MS    = 2'd0;
  localparam logic [1:0] REG_SLOT_COUNT = 2'd1;
  localparam logic [1:0] REG_MAX_TIMERS = 2'd2;
  localparam logic [1:0] REG_ADD_ENABLE = 2'd3;

  typedef struct packed {
    logic [15:0] tick_ms;
    logic [8:0]  slot_count;
    logic [5:0]  max_timers;
    logic        add_enable;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] interval_ms;
    logic        repeat_req;
    logic [1:0]  run_mode;
    logic [5:0]  target_id;
    logic        tid_ok;
  } cmd_t;

endpackage

[hw/rtl/hashed_timing_wheel_scheduler_core.sv]
// ----------------------------------------------------------------------------
// hashed_timing_wheel_scheduler_core
// Timer table on a hashed wheel: add, delete, delete all and tick requests.
// ----------------------------------------------------------------------------
//  channel | ports                       | beat
//  in      | in_valid/in_ready + fields  | one request
//  out     | out_valid/out_ready + fields| one reply, expiry or tick done
//  cfg     | cfg_psel..cfg_pready        | one register write or read
//
//  Add: three passes through the shared divider. Tick: scans every table
//  entry, and each repeat timer that fires is re-armed through the same
//  three divider passes.
//  Synchronous reset clears the table valid bits, wheel position and live count.
//  A two-beat queue takes requests while the engine works or out stalls.
// ----------------------------------------------------------------------------
module hashed_timing_wheel_scheduler_core import htw_pkg::*; #(
  parameter int MAX_TIMERS  = 32,
  parameter int WHEEL_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_interval_ms,
  input  logic        in_repeat_req,
  input  logic [1:0]  in_run_mode,
  input  logic [5:0]  in_target_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_resp_kind,
  output logic [5:0]  out_result_id,
  output logic [2:0]  out_status,
  output logic [1:0]  out_fire_mode,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t cfg_r;
  cmd_t front_cmd, q_cmd;
  logic q_valid, q_ready;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_ms    <= 16'd10;
      cfg_r.slot_count <= 9'd256;
      cfg_r.max_timers <= 6'd32;
      cfg_r.add_enable <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[3:2])
        REG_TICK_MS:    cfg_r.tick_ms    <= cfg_pwdata[15:0];
        REG_SLOT_COUNT: cfg_r.slot_count <= cfg_pwdata[8:0];
        REG_MAX_TIMERS: cfg_r.max_timers <= cfg_pwdata[5:0];
        REG_ADD_ENABLE: cfg_r.add_enable <= cfg_pwdata[0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_TICK_MS:    cfg_prdata = 32'(cfg_r.tick_ms);
      REG_SLOT_COUNT: cfg_prdata = 32'(cfg_r.slot_count);
      REG_MAX_TIMERS: cfg_prdata = 32'(cfg_r.max_timers);
      REG_ADD_ENABLE: cfg_prdata = 32'(cfg_r.add_enable);
      default:        cfg_prdata = 32'd0;
    endcase
  end

  htw_front #(.MAX_TIMERS(MAX_TIMERS)) u_front (
    .req_type    (in_req_type),
    .interval_ms (in_interval_ms),
    .repeat_req  (in_repeat_req),
    .run_mode    (in_run_mode),
    .target_id   (in_target_id),
    .cmd         (front_cmd)
  );

  htw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  htw_engine #(.MAX_TIMERS(MAX_TIMERS), .WHEEL_SLOTS(WHEEL_SLOTS)) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cmd_valid     (q_valid),
    .cmd_ready     (q_ready),
    .cmd           (q_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_resp_kind (out_resp_kind),
    .out_result_id (out_result_id),
    .out_status    (out_status),
    .out_fire_mode (out_fire_mode),
    .out_last      (out_last)
  );

endmodule

[hw/rtl/htw_front.sv]
// ----------------------------------------------------------------------------
// htw_front
// Decodes an incoming request beat into a command and range-checks its id.
// ----------------------------------------------------------------------------
module htw_front import htw_pkg::*; #(
  parameter int MAX_TIMERS = 32
) (
  input  logic [1:0]  req_type,
  input  logic [31:0] interval_ms,
  input  logic        repeat_req,
  input  logic [1:0]  run_mode,
  input  logic [5:0]  target_id,
  output cmd_t        cmd
);

  always_comb begin
    unique case (req_type)
      OP_ADD:     cmd.op = OP_ADD;
      OP_DEL:     cmd.op = OP_DEL;
      OP_DEL_ALL: cmd.op = OP_DEL_ALL;
      default:    cmd.op = OP_TICK;
    endcase
    cmd.interval_ms = interval_ms;
    cmd.repeat_req  = repeat_req;
    cmd.run_mode    = run_mode;
    cmd.target_id   = target_id;
    cmd.tid_ok      = (target_id != 6'd0) && (7'(target_id) <= 7'(MAX_TIMERS));
  end

endmodule

[hw/rtl/htw_queue.sv]
// ----------------------------------------------------------------------------
// htw_queue
// Two-entry command queue between request decode and the wheel engine.
// ----------------------------------------------------------------------------
module htw_queue import htw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_cmd    = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_cmd;
  end

endmodule

[hw/rtl/htw_div.sv]
// ----------------------------------------------------------------------------
// htw_div
// Restoring divider, one quotient bit per cycle, 33-bit dividend.
// ----------------------------------------------------------------------------
module htw_div #(
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [32:0]   dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [32:0]   quot,
  output logic [VW-1:0] rem
);

  logic [32:0]   quo_r;
  logic [VW-1:0] rem_r, dvs_r;
  logic [5:0]    cnt_r;
  logic          busy_r, done_r;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[32]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign done  = done_r;
  assign quot  = quo_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 6'd1);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd33;
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? VW'(trial - {1'b0, dvs_r}) : VW'(trial);
        quo_r <= {quo_r[31:0], fits};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) busy_r <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/htw_engine.sv]
// ----------------------------------------------------------------------------
// htw_engine
// Timer table, wheel position and result register; executes queued commands.
// ----------------------------------------------------------------------------
module htw_engine import htw_pkg::*; #(
  parameter int MAX_TIMERS  = 32,
  parameter int WHEEL_SLOTS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_resp_kind,
  output logic [5:0] out_result_id,
  output logic [2:0] out_status,
  output logic [1:0] out_fire_mode,
  output logic       out_last
);

  localparam int AW  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int SW  = $clog2(WHEEL_SLOTS);
  localparam int SCW = (SW + 1 > 9) ? SW + 1 : 9;
  localparam int VW  = (SCW > 16) ? SCW : 16;
  localparam int LW  = $clog2(MAX_TIMERS + 1);

  typedef struct packed {
    logic [SW-1:0] slot;
    logic [31:0]   rounds;
    logic [31:0]   interval;
    logic          rep;
    logic [1:0]    mode;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_REPLY, S_SCAN, S_LOOK, S_FIRE, S_NEXT,
    S_DIV1, S_DIV2, S_DIV3, S_TDONE
  } state_t;

  state_t                state_r;
  logic [MAX_TIMERS-1:0] valid_r;
  logic [LW-1:0]         live_r;
  logic [SW-1:0]         cs_r;
  logic [AW-1:0]         idx_r, pl_idx_r;
  logic [31:0]           pl_int_r, rounds_r;
  logic                  pl_rep_r, pl_tick_r;
  logic [1:0]            pl_mode_r;
  rec_t                  cur_r, rd_data_r, wr_data_r;
  logic                  wr_req_r;
  logic [AW-1:0]         wr_addr_r;
  logic [1:0]            res_kind_r;
  logic [5:0]            res_id_r;
  logic [2:0]            res_status_r;
  logic                  out_valid_r, out_last_r;
  logic [1:0]            out_kind_r, out_mode_r;
  logic [5:0]            out_id_r;
  logic [2:0]            out_status_r;
  logic                  div_start_r;
  logic [32:0]           div_dvd_r;
  logic [VW-1:0]         div_dvs_r;
  logic                  div_done;
  logic [32:0]           div_quot;
  logic [VW-1:0]         div_rem;

  rec_t mem [MAX_TIMERS];

  logic [15:0]    tick_eff;
  logic [SCW-1:0] slots_ext, slots_eff;
  logic [5:0]     lim;
  logic           free_found;
  logic [AW-1:0]  free_idx;
  logic           can_emit;
  logic [AW-1:0]  tid_idx;

  always_comb begin
    tick_eff  = (cfg.tick_ms == 16'd0) ? 16'd1 : cfg.tick_ms;
    slots_ext = SCW'(cfg.slot_count);
    if (slots_ext < SCW'(2))                slots_eff = SCW'(2);
    else if (slots_ext > SCW'(WHEEL_SLOTS)) slots_eff = SCW'(WHEEL_SLOTS);
    else                                    slots_eff = slots_ext;
    if (cfg.max_timers == 6'd0)                     lim = 6'd1;
    else if (7'(cfg.max_timers) > 7'(MAX_TIMERS))   lim = 6'(MAX_TIMERS);
    else                                            lim = cfg.max_timers;
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  assign can_emit  = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == S_IDLE);
  assign tid_idx   = AW'(cmd.target_id - 6'd1);

  assign out_valid     = out_valid_r;
  assign out_resp_kind = out_kind_r;
  assign out_result_id = out_id_r;
  assign out_status    = out_status_r;
  assign out_fire_mode = out_mode_r;
  assign out_last      = out_last_r;

  htw_div #(.VW(VW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dvd_r),
    .divisor  (div_dvs_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (wr_req_r) mem[wr_addr_r] <= wr_data_r;
    rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      live_r      <= '0;
      cs_r        <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      wr_req_r    <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      wr_req_r    <= 1'b0;
      div_start_r <= 1'b0;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.op)
              OP_ADD: begin
                res_kind_r <= KIND_ADD;
                res_id_r   <= 6'd0;
                if (!cfg.add_enable) begin
                  res_status_r <= ST_DISABLED;
                  state_r      <= S_REPLY;
                end else if (6'(live_r) >= lim || !free_found) begin
                  res_status_r <= ST_FULL;
                  state_r      <= S_REPLY;
                end else if (cmd.interval_ms < 32'(tick_eff)) begin
                  res_status_r <= ST_SHORT;
                  state_r      <= S_REPLY;
                end else begin
                  res_status_r <= ST_OK;
                  pl_idx_r     <= free_idx;
                  pl_int_r     <= cmd.interval_ms;
                  pl_rep_r     <= cmd.repeat_req;
                  pl_mode_r    <= cmd.run_mode;
                  pl_tick_r    <= 1'b0;
                  div_dvd_r    <= {1'b0, cmd.interval_ms};
                  div_dvs_r    <= VW'(tick_eff);
                  div_start_r  <= 1'b1;
                  state_r      <= S_DIV1;
                end
              end
              OP_DEL: begin
                res_kind_r <= KIND_DEL;
                state_r    <= S_REPLY;
                if (cmd.tid_ok && valid_r[tid_idx]) begin
                  valid_r[tid_idx] <= 1'b0;
                  if (live_r != '0) live_r <= live_r - LW'(1);
                  res_id_r     <= cmd.target_id;
                  res_status_r <= ST_OK;
                end else begin
                  res_id_r     <= 6'd0;
                  res_status_r <= ST_NOT_FOUND;
                end
              end
              OP_DEL_ALL: begin
                res_kind_r   <= KIND_DEL;
                res_id_r     <= 6'd0;
                res_status_r <= (|valid_r) ? ST_OK : ST_EMPTY;
                valid_r      <= '0;
                live_r       <= '0;
                state_r      <= S_REPLY;
              end
              OP_TICK: begin
                idx_r   <= '0;
                state_r <= S_SCAN;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_REPLY: begin
          if (can_emit) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= res_kind_r;
            out_id_r     <= res_id_r;
            out_status_r <= res_status_r;
            out_mode_r   <= 2'd0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_SCAN: begin
          state_r <= valid_r[idx_r] ? S_LOOK : S_NEXT;
        end
        S_LOOK: begin
          cur_r <= rd_data_r;
          if (rd_data_r.slot != cs_r) begin
            state_r <= S_NEXT;
          end else if (rd_data_r.rounds != 32'd0) begin
            wr_req_r  <= 1'b1;
            wr_addr_r <= idx_r;
            wr_data_r <= {rd_data_r.slot, rd_data_r.rounds - 32'd1, rd_data_r.interval,
                          rd_data_r.rep, rd_data_r.mode};
            state_r   <= S_NEXT;
          end else begin
            state_r <= S_FIRE;
          end
        end
        S_FIRE: begin
          if (can_emit) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= KIND_EXPIRY;
            out_id_r     <= 6'(idx_r) + 6'd1;
            out_status_r <= ST_OK;
            out_mode_r   <= cur_r.mode;
            out_last_r   <= 1'b0;
            if (cur_r.rep) begin
              pl_idx_r    <= idx_r;
              pl_int_r    <= cur_r.interval;
              pl_rep_r    <= cur_r.rep;
              pl_mode_r   <= cur_r.mode;
              pl_tick_r   <= 1'b1;
              div_dvd_r   <= {1'b0, cur_r.interval};
              div_dvs_r   <= VW'(tick_eff);
              div_start_r <= 1'b1;
              state_r     <= S_DIV1;
            end else begin
              valid_r[idx_r] <= 1'b0;
              if (live_r != '0) live_r <= live_r - LW'(1);
              state_r <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          if (idx_r == AW'(MAX_TIMERS - 1)) begin
            state_r <= S_TDONE;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_SCAN;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            div_dvd_r   <= div_quot;
            div_dvs_r   <= VW'(slots_eff);
            div_start_r <= 1'b1;
            state_r     <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            rounds_r    <= div_quot[31:0];
            div_dvd_r   <= 33'(cs_r) + 33'(div_rem);
            div_start_r <= 1'b1;
            state_r     <= S_DIV3;
          end
        end
        S_DIV3: begin
          if (div_done) begin
            wr_req_r  <= 1'b1;
            wr_addr_r <= pl_idx_r;
            wr_data_r <= {SW'(div_rem), rounds_r, pl_int_r, pl_rep_r, pl_mode_r};
            if (pl_tick_r) begin
              state_r <= S_NEXT;
            end else begin
              valid_r[pl_idx_r] <= 1'b1;
              live_r            <= live_r + LW'(1);
              res_id_r          <= 6'(pl_idx_r) + 6'd1;
              state_r           <= S_REPLY;
            end
          end
        end
        S_TDONE: begin
          if (can_emit) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= KIND_TICK;
            out_id_r     <= 6'd0;
            out_status_r <= ST_OK;
            out_mode_r   <= 2'd0;
            out_last_r   <= 1'b1;
            if (SCW'(cs_r) >= slots_eff - SCW'(1)) cs_r <= '0;
            else                                   cs_r <= cs_r + SW'(1);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/htw_checker.sv]
// ----------------------------------------------------------------------------
// htw_checker
// Port-level checks of the timing wheel scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module htw_checker import htw_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_resp_kind,
  input logic [5:0]  out_result_id,
  input logic [2:0]  out_status,
  input logic [1:0]  out_fire_mode,
  input logic        out_last,
  input logic        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_id)
      && $stable(out_resp_kind))
    else $error("out beat changed while stalled");

  a_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_resp_kind == KIND_EXPIRY |->
      !out_last && out_status == ST_OK && out_result_id != 6'd0)
    else $error("bad expiry beat");

  a_tick_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_resp_kind == KIND_TICK |->
      out_last && out_result_id == 6'd0 && out_fire_mode == 2'd0)
    else $error("bad tick done beat");

  a_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_resp_kind == KIND_ADD || out_resp_kind == KIND_DEL) |->
      out_last && ((out_status == ST_OK) == (out_result_id != 6'd0)
      || (out_resp_kind == KIND_DEL && out_status == ST_OK)))
    else $error("bad reply beat");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready dropped");

endmodule

bind hashed_timing_wheel_scheduler_core htw_checker u_htw_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hashed timing wheel scheduler core.
// Requests go in through a bursty valid/ready sender. Every reply, expiry and
// tick-done beat is checked against a cycle-free model of the timer table and
// wheel. The run walks several register settings, the extremes among them,
// written over the register port while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import htw_pkg::*;

  localparam int NTIM       = 32;
  localparam int NSLOT      = 256;
  localparam int IDLE_LIMIT = 40000;
  localparam int SETTLE     = 300;

  typedef struct {
    logic [1:0] kind;
    logic [5:0] id;
    logic [2:0] st;
    logic [1:0] mode;
    logic       last;
  } beat_t;

  typedef struct {
    op_t         op;
    logic [31:0] ival;
    logic        rep;
    logic [1:0]  mode;
    logic [5:0]  tid;
    logic        typed;
    logic [1:0]  kind;
    logic [5:0]  id;
    logic [2:0]  st;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = '0;
  logic [31:0] in_interval_ms = '0;
  logic        in_repeat_req = 1'b0;
  logic [1:0]  in_run_mode = '0;
  logic [5:0]  in_target_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_resp_kind;
  logic [5:0]  out_result_id;
  logic [2:0]  out_status;
  logic [1:0]  out_fire_mode;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  hashed_timing_wheel_scheduler_core u_dut (.*);

  always #5 clk = ~clk;

  // wheel state mirror
  logic [15:0] m_tick;
  logic [8:0]  m_slots;
  logic [5:0]  m_maxt;
  logic        m_en;
  logic        t_valid [NTIM];
  logic [31:0] t_slot [NTIM];
  logic [31:0] t_rounds [NTIM];
  logic [31:0] t_ival [NTIM];
  logic        t_rep [NTIM];
  logic [1:0]  t_mode [NTIM];
  int          free_id, wheel_pos, live;

  beat_t pending_results[$];
  int    errors, mismatches, n_items, n_beats, n_fired, idle_cycles, burst_left;

  function automatic longint tick_len();
    return (m_tick == 0) ? 1 : longint'(m_tick);
  endfunction

  function automatic longint slot_span();
    if (m_slots < 2) return 2;
    if (m_slots > NSLOT) return NSLOT;
    return m_slots;
  endfunction

  function automatic int timer_limit();
    if (m_maxt < 1) return 1;
    if (m_maxt > NTIM) return NTIM;
    return m_maxt;
  endfunction

  function automatic void find_free();
    free_id = 0;
    for (int i = NTIM - 1; i >= 0; i--) if (!t_valid[i]) free_id = i + 1;
  endfunction

  function automatic void arm_timer(int k);
    longint tl, sl, iv;
    tl = tick_len();
    sl = slot_span();
    iv = longint'(t_ival[k]);
    t_slot[k]   = 32'((longint'(wheel_pos) + iv / tl) % sl);
    t_rounds[k] = 32'(iv / (tl * sl));
  endfunction

  function automatic void push_beat(logic [1:0] kind, logic [5:0] id, logic [2:0] st,
                                    logic [1:0] mode, logic last);
    beat_t b;
    b.kind = kind; b.id = id; b.st = st; b.mode = mode; b.last = last;
    pending_results.push_back(b);
  endfunction

  function automatic void wheel_reset();
    m_tick = 16'd10; m_slots = 9'd256; m_maxt = 6'd32; m_en = 1'b1;
    for (int i = 0; i < NTIM; i++) t_valid[i] = 1'b0;
    free_id = 1; wheel_pos = 0; live = 0;
  endfunction

  function automatic void predict_request(op_t op, logic [31:0] ival, logic rep,
                                          logic [1:0] mode, logic [5:0] tid);
    logic [2:0] st;
    int k;
    logic any;
    logic due [NTIM];
    case (op)
      OP_ADD: begin
        st = ST_OK;
        if (!m_en) st = ST_DISABLED;
        else if (live >= timer_limit() || free_id == 0) st = ST_FULL;
        else if (longint'(ival) < tick_len()) st = ST_SHORT;
        if (st == ST_OK) begin
          k = free_id - 1;
          t_valid[k] = 1'b1; t_ival[k] = ival; t_rep[k] = rep; t_mode[k] = mode;
          arm_timer(k);
          live++;
          find_free();
          push_beat(KIND_ADD, 6'(k + 1), ST_OK, 2'd0, 1'b1);
        end else begin
          push_beat(KIND_ADD, 6'd0, st, 2'd0, 1'b1);
        end
      end
      OP_DEL: begin
        if (tid >= 1 && tid <= NTIM && t_valid[tid - 1]) begin
          t_valid[tid - 1] = 1'b0;
          if (live > 0) live--;
          find_free();
          push_beat(KIND_DEL, tid, ST_OK, 2'd0, 1'b1);
        end else begin
          push_beat(KIND_DEL, 6'd0, ST_NOT_FOUND, 2'd0, 1'b1);
        end
      end
      OP_DEL_ALL: begin
        any = 1'b0;
        for (int i = 0; i < NTIM; i++) begin
          any |= t_valid[i];
          t_valid[i] = 1'b0;
        end
        live = 0;
        free_id = 1;
        push_beat(KIND_DEL, 6'd0, any ? ST_OK : ST_EMPTY, 2'd0, 1'b1);
      end
      default: begin
        for (int i = 0; i < NTIM; i++) due[i] = t_valid[i] && t_slot[i] == wheel_pos;
        for (int i = 0; i < NTIM; i++) begin
          if (due[i]) begin
            if (t_rounds[i] != 0) begin
              t_rounds[i]--;
            end else begin
              push_beat(KIND_EXPIRY, 6'(i + 1), ST_OK, t_mode[i], 1'b0);
              if (t_rep[i]) begin
                arm_timer(i);
              end else begin
                t_valid[i] = 1'b0;
                if (live > 0) live--;
              end
            end
          end
        end
        find_free();
        push_beat(KIND_TICK, 6'd0, ST_OK, 2'd0, 1'b1);
        if (longint'(wheel_pos) >= slot_span() - 1) wheel_pos = 0;
        else wheel_pos++;
      end
    endcase
  endfunction

  function automatic void flag(string what, longint e, longint a);
    errors++;
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, e, a);
  endfunction

  // result checker
  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_valid && out_ready) begin
      n_beats++;
      if (out_resp_kind == KIND_EXPIRY) n_fired++;
      if (pending_results.size() == 0) begin
        flag("unexpected beat, kind", -1, out_resp_kind);
      end else begin
        e = pending_results.pop_front();
        if (out_resp_kind !== e.kind) flag("resp_kind", e.kind, out_resp_kind);
        if (out_result_id !== e.id) flag("result_id", e.id, out_result_id);
        if (out_status !== e.st) flag("status", e.st, out_status);
        if (out_fire_mode !== e.mode) flag("fire_mode", e.mode, out_fire_mode);
        if (out_last !== e.last) flag("last", e.last, out_last);
      end
    end
  end

  // receiver stall pattern
  int rx_cyc;
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    case (rx_cyc[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (rx_cyc[2:0] < 3);
      default: out_ready <= (rx_cyc[5:0] > 50);
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic send_beat(op_t op, logic [31:0] ival, logic rep, logic [1:0] mode,
                           logic [5:0] tid);
    in_valid       <= 1'b1;
    in_req_type    <= op;
    in_interval_ms <= ival;
    in_repeat_req  <= rep;
    in_run_mode    <= mode;
    in_target_id   <= tid;
    do @(posedge clk); while (!in_ready);
    n_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    logic [31:0] mask;
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_pwrite <= 1'b0; cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_TICK_MS:    begin m_tick  = val[15:0]; mask = 32'h0000_FFFF; end
      REG_SLOT_COUNT: begin m_slots = val[8:0];  mask = 32'h0000_01FF; end
      REG_MAX_TIMERS: begin m_maxt  = val[5:0];  mask = 32'h0000_003F; end
      default:        begin m_en    = val[0];    mask = 32'h0000_0001; end
    endcase
    if (cfg_prdata !== (val & mask))
      flag("register readback", val & mask, cfg_prdata);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] tk, logic [31:0] sl, logic [31:0] mx, logic [31:0] en);
    reg_write(REG_TICK_MS, tk);
    reg_write(REG_SLOT_COUNT, sl);
    reg_write(REG_MAX_TIMERS, mx);
    reg_write(REG_ADD_ENABLE, en);
  endtask

  task automatic random_items(int count);
    int r;
    longint span;
    logic [31:0] iv;
    op_t op;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      span = tick_len() * slot_span() * 3;
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      iv = 32'($urandom_range(0, 32'(span)));
      if (r < 35) op = OP_ADD;
      else if (r < 45) op = OP_DEL;
      else if (r < 48) op = OP_DEL_ALL;
      else op = OP_TICK;
      if (op == OP_ADD && $urandom_range(0, 9) == 0) iv = $urandom();
      if (n == count / 2) drain();
      send_beat(op, iv, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(1, 8)));
      predict_request(op, in_interval_ms, in_repeat_req, in_run_mode, in_target_id);
    end
  endtask

  function automatic row_t mk(op_t op, logic [31:0] ival, logic rep, logic [1:0] mode,
                              logic [5:0] tid, logic typed, logic [1:0] kind,
                              logic [5:0] id, logic [2:0] st);
    row_t r;
    r.op = op; r.ival = ival; r.rep = rep; r.mode = mode; r.tid = tid;
    r.typed = typed; r.kind = kind; r.id = id; r.st = st;
    return r;
  endfunction

  initial begin
    row_t plan[$];
    row_t r;
    errors = 0; mismatches = 0; n_items = 0; n_beats = 0; n_fired = 0;
    idle_cycles = 0; burst_left = 0; rx_cyc = 0;
    wheel_reset();
    plan = '{
      mk(OP_DEL_ALL, 0, 0, 0, 0, 1, KIND_DEL, 0, ST_EMPTY),
      mk(OP_DEL, 0, 0, 0, 0, 1, KIND_DEL, 0, ST_NOT_FOUND),
      mk(OP_DEL, 0, 0, 0, 63, 1, KIND_DEL, 0, ST_NOT_FOUND),
      mk(OP_DEL, 0, 0, 0, 1, 1, KIND_DEL, 0, ST_NOT_FOUND),
      mk(OP_ADD, 9, 1, 1, 0, 1, KIND_ADD, 0, ST_SHORT),
      mk(OP_ADD, 0, 0, 0, 0, 1, KIND_ADD, 0, ST_SHORT),
      mk(OP_ADD, 10, 1, 3, 0, 1, KIND_ADD, 1, ST_OK),
      mk(OP_ADD, 32'hFFFF_FFFF, 0, 2, 63, 1, KIND_ADD, 2, ST_OK),
      mk(OP_ADD, 20, 0, 1, 0, 1, KIND_ADD, 3, ST_OK),
      mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(OP_TICK, 32'hFFFF_FFFF, 1, 3, 63, 0, 0, 0, 0),
      mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(OP_DEL, 0, 0, 0, 2, 1, KIND_DEL, 2, ST_OK),
      mk(OP_DEL, 0, 0, 0, 2, 1, KIND_DEL, 0, ST_NOT_FOUND),
      mk(OP_ADD, 2560, 1, 0, 0, 0, 0, 0, 0),
      mk(OP_DEL, 0, 0, 0, 33, 1, KIND_DEL, 0, ST_NOT_FOUND),
      mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(OP_DEL_ALL, 0, 0, 0, 0, 1, KIND_DEL, 0, ST_OK),
      mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0)
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      r = plan[i];
      send_beat(r.op, r.ival, r.rep, r.mode, r.tid);
      predict_request(r.op, r.ival, r.rep, r.mode, r.tid);
      if (r.typed) begin
        void'(pending_results.pop_back());
        push_beat(r.kind, r.id, r.st, 2'd0, 1'b1);
      end
    end
    drain();

    // fill the whole table, then overflow it
    for (int n = 0; n < 34; n++) begin
      send_beat(OP_ADD, 32'h4000_0000 + n, 1'b0, 2'($urandom_range(0, 3)), 6'd0);
      predict_request(OP_ADD, in_interval_ms, in_repeat_req, in_run_mode, in_target_id);
    end
    random_items(50);
    drain();

    set_regs(1, 2, 32, 1);
    random_items(60);
    drain();
    set_regs(65535, 4, 1, 1);
    random_items(50);
    drain();
    set_regs(0, 0, 63, 1);
    random_items(60);
    drain();
    set_regs(3, 511, 0, 0);
    random_items(25);
    drain();
    set_regs(7, 9, 20, 1);
    random_items(70);
    drain();
    set_regs(10, 256, 32, 1);
    random_items(40);
    drain();

    if (pending_results.size() != 0) flag("leftover expectations", 0, pending_results.size());
    $display("covered %0d requests, %0d result beats, %0d expiries", n_items, n_beats, n_fired);
    $display("over seven register settings with bursty input and stalled output");
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule

[files.f]
hw/rtl/htw_pkg.sv
hw/rtl/htw_front.sv
hw/rtl/htw_queue.sv
hw/rtl/htw_div.sv
hw/rtl/htw_engine.sv
hw/rtl/hashed_timing_wheel_scheduler_core.sv
hw/rtl/htw_checker.sv
verif/tb_top.sv
